// ===== hw/rtl/tsc_pkg.sv =====
// ----------------------------------------------------------------------------
// tsc_pkg
// Types, constants and helpers shared by the trajectory segment
// coefficient unit and its serial multiplier and divider.
// ----------------------------------------------------------------------------
package tsc_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int WIDE_W        = 128;
  localparam int OPND_W        = 65;

  // result status codes
  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_ZERO = 2'd1;
  localparam logic [1:0] ST_SAT  = 2'd2;

  typedef struct packed {
    logic               start_new;
    logic signed [31:0] time_point;
    logic signed [31:0] path_position;
    logic signed [31:0] path_speed;
  } tsc_in_t;

  typedef struct packed {
    logic        [15:0] segment_index;
    logic signed [63:0] coef_zero;
    logic signed [63:0] coef_one;
    logic signed [63:0] coef_two;
    logic signed [63:0] coef_three;
    logic        [1:0]  status;
  } tsc_out_t;

  // sequencer states
  typedef enum logic [3:0] {
    S_IDLE, S_LOAD, S_HM1, S_HM2, S_HM3, S_HM4, S_HD2, S_HD3,
    S_MAC, S_MRND, S_MADD, S_AM, S_AD, S_DONE
  } tsc_state_t;

  typedef enum logic [1:0] {M_IDLE, M_ABS, M_RUN} mul_phase_t;
  typedef enum logic [2:0] {D_IDLE, D_ABS, D_RUN, D_ROUND, D_SIGN} div_phase_t;

  // multiplier request / response
  typedef struct packed {
    logic              start;
    logic [OPND_W-1:0] a;      // signed operands
    logic [OPND_W-1:0] b;
  } mul_req_t;

  typedef struct packed {
    logic              done;
    logic              neg;    // sign of the product
    logic [WIDE_W-1:0] mag;    // magnitude of the product
  } mul_rsp_t;

  // divider request / response
  typedef struct packed {
    logic              start;
    logic              flip;   // invert the sign of the quotient
    logic [WIDE_W-1:0] num;    // signed numerator
    logic [WIDE_W-1:0] den;    // unsigned, nonzero denominator
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [WIDE_W-1:0] quo;    // signed rounded quotient
  } div_rsp_t;

  typedef struct packed {
    logic        hit;
    logic [63:0] val;
  } sat_t;

  // clamp a 128-bit signed value to 64 bits
  function automatic sat_t sat64(input logic [WIDE_W-1:0] x);
    sat_t r;
    if (&x[WIDE_W-1:63] || ~|x[WIDE_W-1:63]) begin
      r.hit = 1'b0;
      r.val = x[63:0];
    end else begin
      r.hit = 1'b1;
      r.val = x[WIDE_W-1] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
    end
    return r;
  endfunction

endpackage

// ===== hw/rtl/tsc_mul.sv =====
// ----------------------------------------------------------------------------
// tsc_mul
// Shift-add multiplier: signed operands in, sign and 128-bit magnitude out.
// One add per cycle, stops once the remaining multiplier bits are zero.
// ----------------------------------------------------------------------------
module tsc_mul (
  input  logic              clk,
  input  logic              rst,
  input  tsc_pkg::mul_req_t req,
  output tsc_pkg::mul_rsp_t rsp
);
  import tsc_pkg::*;

  mul_phase_t        phase, phase_next;
  logic [OPND_W-1:0] a_in, b_in;
  logic [WIDE_W-1:0] am, acc;
  logic [63:0]       bm;
  logic              neg, done;

  function automatic logic [63:0] abs64(input logic [OPND_W-1:0] x);
    logic [OPND_W-1:0] n;
    n = x[OPND_W-1] ? ~x + 1'b1 : x;
    return n[63:0];
  endfunction

  // next phase
  always_comb begin
    phase_next = phase;
    case (phase)
      M_IDLE:  if (req.start) phase_next = M_ABS;
      M_ABS:   phase_next = M_RUN;
      M_RUN:   if (bm == '0) phase_next = M_IDLE;
      default: phase_next = M_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    rsp.done = done;
    rsp.neg  = neg;
    rsp.mag  = acc;
  end

  // datapath
  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= M_IDLE;
      done  <= 1'b0;
    end else begin
      phase <= phase_next;
      done  <= (phase == M_RUN) && (bm == '0);
      case (phase)
        M_IDLE: begin
          if (req.start) begin
            a_in <= req.a;
            b_in <= req.b;
          end
        end
        M_ABS: begin
          am  <= {64'd0, abs64(a_in)};
          bm  <= abs64(b_in);
          neg <= a_in[OPND_W-1] ^ b_in[OPND_W-1];
          acc <= '0;
        end
        M_RUN: begin
          if (bm != '0) begin
            if (bm[0]) acc <= acc + am;
            am <= am << 1;
            bm <= bm >> 1;
          end
        end
        default: ;
      endcase
    end
  end

endmodule

// ===== hw/rtl/tsc_div.sv =====
// ----------------------------------------------------------------------------
// tsc_div
// Restoring divider, one quotient bit per cycle over 128 bits, then round
// half away from zero and apply the sign.
// ----------------------------------------------------------------------------
module tsc_div (
  input  logic              clk,
  input  logic              rst,
  input  tsc_pkg::div_req_t req,
  output tsc_pkg::div_rsp_t rsp
);
  import tsc_pkg::*;

  div_phase_t        phase, phase_next;
  logic [WIDE_W-1:0] num_l, nsh, den, r, q;
  logic              flip_l, neg, done;
  logic [6:0]        cnt;
  logic [WIDE_W:0]   rs, diff;
  logic              ge;

  // trial subtract
  always_comb begin
    rs   = {r, nsh[WIDE_W-1]};
    diff = rs - {1'b0, den};
    ge   = rs >= {1'b0, den};
  end

  // next phase
  always_comb begin
    phase_next = phase;
    case (phase)
      D_IDLE:  if (req.start) phase_next = D_ABS;
      D_ABS:   phase_next = D_RUN;
      D_RUN:   if (cnt == 7'd127) phase_next = D_ROUND;
      D_ROUND: phase_next = D_SIGN;
      D_SIGN:  phase_next = D_IDLE;
      default: phase_next = D_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    rsp.done = done;
    rsp.quo  = q;
  end

  // datapath
  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= D_IDLE;
      done  <= 1'b0;
    end else begin
      phase <= phase_next;
      done  <= (phase == D_SIGN);
      case (phase)
        D_IDLE: begin
          if (req.start) begin
            num_l  <= req.num;
            flip_l <= req.flip;
            den    <= req.den;
          end
        end
        D_ABS: begin
          nsh <= num_l[WIDE_W-1] ? ~num_l + 1'b1 : num_l;
          neg <= num_l[WIDE_W-1] ^ flip_l;
          r   <= '0;
          q   <= '0;
          cnt <= '0;
        end
        D_RUN: begin
          r   <= ge ? diff[WIDE_W-1:0] : rs[WIDE_W-1:0];
          q   <= {q[WIDE_W-2:0], ge};
          nsh <= nsh << 1;
          cnt <= cnt + 1'b1;
        end
        D_ROUND: begin
          // remainder at least half the divisor rounds the magnitude up
          if ({r, 1'b0} >= {1'b0, den}) q <= q + 1'b1;
        end
        D_SIGN: begin
          if (neg) q <= ~q + 1'b1;
        end
        default: ;
      endcase
    end
  end

endmodule

// ===== hw/rtl/trajectory_segment_coefficients_unit.sv =====
// ----------------------------------------------------------------------------
// trajectory_segment_coefficients_unit
// Segment polynomial coefficients from consecutive trajectory grid points.
// ----------------------------------------------------------------------------
// One grid point is taken per transfer; after a point that gives a result
// the block holds in_stall high until that result sits in the output
// register. A first point (start_new, or none held yet) is stored without
// raising in_stall and gives no result. Every other point runs a sequencer
// over one shift-add multiplier (which finishes early when the second
// operand is short) and one restoring divider, with a launch and a done
// handshake around each operation. From one accepted point to the next:
// constant-acceleration mode runs one product of 33-bit operands and one
// quotient, hermite mode four short products, two quotients and six
// full-width products each followed by a rounding step and an accumulation
// step, and a zero span goes straight to the result. The output register
// lets a finished result wait while the next point is taken.
// ----------------------------------------------------------------------------
module trajectory_segment_coefficients_unit #(
  parameter int FRAC_BITS = tsc_pkg::FRAC_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_write,
  input  logic              cfg_data,
  input  logic              in_valid,
  output logic              in_stall,
  input  tsc_pkg::tsc_in_t  in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output tsc_pkg::tsc_out_t out_seg
);
  import tsc_pkg::*;

  localparam int               UP   = 32 - FRAC_BITS;
  localparam logic [WIDE_W-1:0] HALF = 128'd1 << (FRAC_BITS - 1);

  tsc_state_t state, state_next;
  logic       entered;
  logic       kind;
  logic signed [31:0] last_t, last_s, last_v, sd0, v1;
  logic       have_last;
  logic [15:0] seg_cnt;
  logic [32:0] dt, ds, h;
  logic [34:0] ds3;
  logic [63:0] c0, c1, c2, c3, dt2;
  logic [WIDE_W-1:0] n2, m3, dt3, rnd;
  logic [2:0] k;
  logic       sat_acc, zero;

  mul_req_t mreq;
  mul_rsp_t mrsp;
  div_req_t dreq;
  div_rsp_t drsp;

  logic        accept, first, zero_span;
  logic [1:0]  j;
  logic [63:0] c_lo, c_hi;
  logic [33:0] sum2;
  logic [32:0] sp, sm, dsabs;
  logic [WIDE_W-1:0] ds3w, ds2w, cw, mac_sum;
  sat_t        sat_mac, sat_div;

  tsc_mul u_mul (.clk(clk), .rst(rst), .req(mreq), .rsp(mrsp));
  tsc_div u_div (.clk(clk), .rst(rst), .req(dreq), .rsp(drsp));

  // handshake and span checks
  assign in_stall  = (state != S_IDLE);
  assign accept    = in_valid && !in_stall;
  assign first     = in_data.start_new || !have_last;
  assign zero_span = kind ? (dt == '0) : (ds == '0);

  // Taylor shift order: target coefficient per step
  always_comb begin
    case (k)
      3'd0:    j = 2'd2;
      3'd1:    j = 2'd1;
      3'd2:    j = 2'd0;
      3'd3:    j = 2'd2;
      3'd4:    j = 2'd1;
      default: j = 2'd2;
    endcase
    case (j)
      2'd0:    begin c_lo = c0; c_hi = c1; end
      2'd1:    begin c_lo = c1; c_hi = c2; end
      default: begin c_lo = c2; c_hi = c3; end
    endcase
  end

  // operand arithmetic
  always_comb begin
    sum2    = {sd0[31], sd0, 1'b0} + {{2{v1[31]}}, v1};
    sp      = {sd0[31], sd0} + {v1[31], v1};
    sm      = {v1[31], v1} - {sd0[31], sd0};
    dsabs   = ds[32] ? ~ds + 1'b1 : ds;
    ds3w    = {{93{ds3[34]}}, ds3} << FRAC_BITS;
    ds2w    = {{95{ds[32]}}, ds} << (FRAC_BITS + 1);
    cw      = {{64{c_lo[63]}}, c_lo};
    mac_sum = mrsp.neg ? cw - rnd : cw + rnd;
    sat_mac = sat64(mac_sum);
    sat_div = sat64(drsp.quo);
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:  if (accept && !first) state_next = S_LOAD;
      S_LOAD: begin
        if (zero_span)  state_next = S_DONE;
        else if (kind)  state_next = S_HM1;
        else            state_next = S_AM;
      end
      S_HM1:   if (mrsp.done) state_next = S_HM2;
      S_HM2:   if (mrsp.done) state_next = S_HM3;
      S_HM3:   if (mrsp.done) state_next = S_HM4;
      S_HM4:   if (mrsp.done) state_next = S_HD2;
      S_HD2:   if (drsp.done) state_next = S_HD3;
      S_HD3:   if (drsp.done) state_next = S_MAC;
      S_MAC:   if (mrsp.done) state_next = S_MRND;
      S_MRND:  state_next = S_MADD;
      S_MADD:  state_next = (k == 3'd5) ? S_DONE : S_MAC;
      S_AM:    if (mrsp.done) state_next = S_AD;
      S_AD:    if (drsp.done) state_next = S_DONE;
      S_DONE:  if (!out_valid || !out_stall) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // unit requests
  always_comb begin
    mreq.start = 1'b0;
    mreq.a     = {{32{dt[32]}}, dt};
    mreq.b     = {{32{dt[32]}}, dt};
    dreq.start = 1'b0;
    dreq.flip  = 1'b0;
    dreq.num   = n2 << 32;
    dreq.den   = {64'd0, dt2};
    case (state)
      S_HM1: begin
        mreq.start = entered;
        mreq.a     = {{31{sum2[33]}}, sum2};
      end
      S_HM2: begin
        mreq.start = entered;
        mreq.a     = {{32{sp[32]}}, sp};
      end
      S_HM3: mreq.start = entered;
      S_HM4: begin
        mreq.start = entered;
        mreq.a     = {1'b0, dt2};
      end
      S_MAC: begin
        mreq.start = entered;
        mreq.a     = {{32{h[32]}}, h};
        mreq.b     = {c_hi[63], c_hi};
      end
      S_AM: begin
        mreq.start = entered;
        mreq.a     = {{32{sm[32]}}, sm};
        mreq.b     = {{32{sp[32]}}, sp};
      end
      S_HD2: dreq.start = entered;
      S_HD3: begin
        dreq.start = entered;
        dreq.flip  = ~dt[32];
        dreq.num   = m3 << (FRAC_BITS + 32);
        dreq.den   = dt3;
      end
      S_AD: begin
        dreq.start = entered;
        dreq.flip  = mrsp.neg ^ ds[32];
        dreq.num   = mrsp.mag << UP;
        dreq.den   = {93'd0, dsabs, 2'b00};
      end
      default: ;
    endcase
  end

  // registers and datapath
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      entered   <= 1'b0;
      kind      <= 1'b0;
      have_last <= 1'b0;
      seg_cnt   <= '0;
      out_valid <= 1'b0;
      last_t    <= '0;
      last_s    <= '0;
      last_v    <= '0;
    end else begin
      state   <= state_next;
      entered <= (state_next != state);
      if (cfg_write) kind <= cfg_data;

      // output register: load a finished segment, drop it after a transfer
      if (state == S_DONE && (!out_valid || !out_stall)) out_valid <= 1'b1;
      else if (out_valid && !out_stall)                  out_valid <= 1'b0;

      case (state)
        S_IDLE: begin
          if (accept) begin
            last_t    <= in_data.time_point;
            last_s    <= in_data.path_position;
            last_v    <= in_data.path_speed;
            have_last <= 1'b1;
            if (in_data.start_new) seg_cnt <= '0;
            dt      <= {in_data.time_point[31], in_data.time_point} - {last_t[31], last_t};
            ds      <= {in_data.path_position[31], in_data.path_position}
                       - {last_s[31], last_s};
            h       <= 33'd0 - {last_t[31], last_t};
            sd0     <= last_v;
            v1      <= in_data.path_speed;
            c0      <= {{32{last_s[31]}}, last_s} << UP;
            c1      <= {{32{last_v[31]}}, last_v} << UP;
            c2      <= '0;
            c3      <= '0;
            k       <= '0;
            sat_acc <= 1'b0;
          end
        end
        S_LOAD: begin
          ds3  <= {{2{ds[32]}}, ds} + {ds[32], ds, 1'b0};
          zero <= zero_span;
        end
        S_HM1: if (mrsp.done) n2 <= mrsp.neg ? ds3w + mrsp.mag : ds3w - mrsp.mag;
        // store the negated cubic numerator; the divider flip restores it
        S_HM2: if (mrsp.done) m3 <= mrsp.neg ? ds2w + mrsp.mag : ds2w - mrsp.mag;
        S_HM3: if (mrsp.done) dt2 <= mrsp.mag[63:0];
        S_HM4: if (mrsp.done) dt3 <= mrsp.mag;
        S_HD2: begin
          if (drsp.done) begin
            c2      <= sat_div.val;
            sat_acc <= sat_acc | sat_div.hit;
          end
        end
        S_HD3: begin
          if (drsp.done) begin
            c3      <= sat_div.val;
            sat_acc <= sat_acc | sat_div.hit;
          end
        end
        S_MRND: rnd <= (mrsp.mag + HALF) >> FRAC_BITS;
        S_MADD: begin
          case (j)
            2'd0:    c0 <= sat_mac.val;
            2'd1:    c1 <= sat_mac.val;
            default: c2 <= sat_mac.val;
          endcase
          sat_acc <= sat_acc | sat_mac.hit;
          k       <= k + 1'b1;
        end
        S_AD: begin
          if (drsp.done) begin
            c2      <= sat_div.val;
            sat_acc <= sat_acc | sat_div.hit;
          end
        end
        S_DONE: begin
          if (!out_valid || !out_stall) begin
            out_seg.segment_index <= seg_cnt;
            out_seg.coef_zero     <= zero ? '0 : c0;
            out_seg.coef_one      <= zero ? '0 : c1;
            out_seg.coef_two      <= zero ? '0 : c2;
            out_seg.coef_three    <= zero ? '0 : c3;
            out_seg.status        <= zero ? ST_ZERO : (sat_acc ? ST_SAT : ST_OK);
            seg_cnt               <= seg_cnt + 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  // the two shared units are never launched together
  a_one_unit: assert property (@(posedge clk) disable iff (rst)
    !(mreq.start && dreq.start))
    else $error("multiplier and divider started in the same cycle");

  // a point that continues a trajectory starts the sequencer
  a_seq_start: assert property (@(posedge clk) disable iff (rst)
    accept && !first |=> state == S_LOAD)
    else $error("segment point did not start the sequencer");

  // a zero span result carries no coefficients
  a_zero_coef: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_seg.status == ST_ZERO |->
      out_seg.coef_zero == '0 && out_seg.coef_one == '0 &&
      out_seg.coef_two == '0 && out_seg.coef_three == '0)
    else $error("zero span result with nonzero coefficients");

  // leaving the final state always loads the output register
  a_result_load: assert property (@(posedge clk) disable iff (rst)
    state == S_DONE && !(out_valid && out_stall) |=> out_valid)
    else $error("finished segment not presented");

endmodule
